// ===== hw/rtl/wcsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcsc_pkg: shared types and constants of the wall-centering step controller
// Widths, op codes, register indexes and the multiply-accumulate controls.
// ----------------------------------------------------------------------------
package wcsc_pkg;

  localparam int SENSOR_BITS     = 10;
  localparam int LOOKAHEAD_STEPS = 60;
  localparam int MASK_STEPS      = 180;

  localparam int OP_W       = 2;
  localparam int GAIN_W     = 9;
  localparam int LEVEL_W    = 10;
  localparam int UNIT_W     = 10;
  localparam int SPB_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int ERR_W   = SENSOR_BITS + 1;   // left minus right
  localparam int DERIV_W = ERR_W + 1;
  localparam int SUM_W   = 32;                // integral term
  localparam int PROD_W  = GAIN_W + SUM_W;
  localparam int MAC_W   = PROD_W + 2;        // sum of three products
  localparam int PID_W   = 10;                // holds +-PID_LIMIT
  localparam int CORR_W  = 12;
  localparam int MASK_W  = 8;
  localparam int LOOK_W  = 6;
  localparam int CNT_W   = 6;

  localparam int PID_LIMIT   = 300;
  localparam int MAX_CORR    = 39;
  localparam int MAX_RESULTS = MAX_CORR + 1;
  localparam int UNIT_MIN    = 8;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_TURN   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP       = 3'd0,
    REG_GAIN_INTEG      = 3'd1,
    REG_GAIN_DERIV      = 3'd2,
    REG_FRONT_ON_LEVEL  = 3'd3,
    REG_FRONT_OFF_LEVEL = 3'd4,
    REG_EMERGENCY_LEVEL = 3'd5,
    REG_CORRECTION_UNIT = 3'd6,
    REG_STEPS_PER_BLOCK = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic mul_en;   // load product register
    logic acc_clr;  // clear accumulator
    logic acc_en;   // add product register into accumulator
  } mac_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wcsc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcsc_if: command and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wcsc_cmd_if import wcsc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [SENSOR_BITS-1:0] left_level;
  logic [SENSOR_BITS-1:0] right_level;
  logic [SENSOR_BITS-1:0] front_level;

  modport source (output valid, op, left_level, right_level, front_level, input ready);
  modport sink   (input valid, op, left_level, right_level, front_level, output ready);
endinterface

interface wcsc_res_if;
  logic valid;
  logic ready;
  logic left_step;
  logic right_step;
  logic slow_mode;
  logic block_done;
  logic emergency_stop;
  logic last;

  modport source (output valid, left_step, right_step, slow_mode, block_done,
                  emergency_stop, last, input ready);
  modport sink   (input valid, left_step, right_step, slow_mode, block_done,
                  emergency_stop, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wcsc_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wcsc_mac: shared multiply-accumulate unit
// One registered gain-by-operand product, summed into a wide accumulator.
// ----------------------------------------------------------------------------
module wcsc_mac import wcsc_pkg::*; (
  input  wire logic                     clk,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [GAIN_W-1:0] a,
  input  wire logic signed [SUM_W-1:0]  b,
  output logic signed [MAC_W-1:0]       acc
);

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + {{(MAC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wall_centering_step_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wall_centering_step_controller: straight-travel step generator with PID
// wall centering, front wall hysteresis and emergency stop.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    op, left_level, right_level, front_level
//   res      out  valid/ready    left_step, right_step, slow_mode,
//                                block_done, emergency_stop, last
//   cfg      in   cfg_wen        cfg_index, cfg_wdata (write only)
//
// Sequence: status items (start, turn, unknown op, sample with no block) and
//   emergency stops go from decode straight to emit. A stepping sample passes
//   through the multiply states (P, I, D), accumulate, clamp and load before
//   emit (1 to 40 results); the shared multiplier runs the three PID products back to back.
// cmd.ready is high only in idle; one item is in flight at a time.
// Reset (rst, synchronous) clears the sequencer and all controller state and
//   loads the register defaults; no clearing pass.
// A stalled result holds; the sequencer waits in the emit state.
// ----------------------------------------------------------------------------
module wall_centering_step_controller import wcsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  wcsc_cmd_if.sink                   cmd,
  wcsc_res_if.source                 res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_CLAMP,
    S_LOAD,
    S_EMIT
  } state_t;

  localparam logic signed [MAC_W-1:0] PID_HI = MAC_W'(PID_LIMIT);
  localparam logic signed [MAC_W-1:0] PID_LO = -PID_HI;

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_prop, gain_integ, gain_deriv;
  logic [LEVEL_W-1:0]       front_on_level, front_off_level, emergency_level;
  logic [UNIT_W-1:0]        correction_unit;
  logic [SPB_W-1:0]         steps_per_block;

  // Sequencer and latched command
  state_t                 state;
  op_t                    op_r;
  logic [SENSOR_BITS-1:0] left_r, right_r, front_r;

  // Controller state
  logic                      front_wall_flag;
  logic [MASK_W-1:0]         front_mask_count;
  logic [LOOK_W-1:0]         lookahead_count;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [CORR_W-1:0]  correction_acc;
  logic [SPB_W-1:0]          step_index;
  logic                      block_active;

  // Per-item working registers
  logic signed [DERIV_W-1:0] deriv_r;
  logic                      done_flag;
  logic                      slow_r;
  logic [CNT_W-1:0]          res_cnt;

  // Result register
  logic out_left, out_right, out_slow, out_done, out_emer, out_last;

  // Shared multiplier
  mac_ctl_t                 mac_ctl;
  logic signed [GAIN_W-1:0] mac_a;
  logic signed [SUM_W-1:0]  mac_b;
  logic signed [MAC_W-1:0]  mac_acc;

  wcsc_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  // Another correction step is due while the accumulator is beyond one unit
  // either way and the per-item cap is not reached.
  function automatic logic corr_more(input logic signed [CORR_W-1:0] acc_v,
                                     input logic [CNT_W-1:0] n,
                                     input logic signed [CORR_W:0] unit_v);
    logic signed [CORR_W:0] a13;
    a13 = {acc_v[CORR_W-1], acc_v};
    return (n <= CNT_W'(MAX_CORR)) && ((a13 > unit_v) || (a13 < -unit_v));
  endfunction

  // ---- front sensor, lookahead, error terms (used in decode) ----
  logic                      flag_next, fb, slow_c;
  logic [LOOK_W-1:0]         la_eff, la_next;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [SUM_W-1:0]   es_next;
  logic signed [DERIV_W-1:0] deriv_c;
  logic [SPB_W-1:0]          step_next, spb_eff;
  logic                      end_c;

  always_comb begin
    if (front_r >= front_on_level) begin
      flag_next = 1'b1;
    end else if (front_r <= front_off_level) begin
      flag_next = 1'b0;
    end else begin
      flag_next = front_wall_flag;
    end
    // masked after a turn: wall taken as absent
    fb = (front_mask_count != '0) ? 1'b0 : flag_next;

    la_eff = (fb && lookahead_count == '0) ? LOOK_W'(LOOKAHEAD_STEPS) : lookahead_count;
    if (la_eff != '0) begin
      slow_c  = 1'b0;
      la_next = la_eff - 1'b1;
    end else begin
      slow_c  = fb;
      la_next = la_eff;
    end

    err_c   = ERR_W'({1'b0, left_r}) - ERR_W'({1'b0, right_r});
    sum_ext = {error_sum[SUM_W-1], error_sum}
            + {{(SUM_W+1-ERR_W){err_c[ERR_W-1]}}, err_c};
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      es_next = {sum_ext[SUM_W], {(SUM_W-1){~sum_ext[SUM_W]}}};
    end else begin
      es_next = sum_ext[SUM_W-1:0];
    end
    deriv_c = {err_c[ERR_W-1], err_c} - {previous_error[ERR_W-1], previous_error};

    step_next = step_index + 1'b1;
    spb_eff   = (steps_per_block == '0) ? SPB_W'(1) : steps_per_block;
    end_c     = (step_next >= spb_eff) || (step_next == '0);
  end

  // ---- PID clamp and correction accumulate (used in clamp) ----
  logic signed [PID_W-1:0]  u_c;
  logic signed [CORR_W:0]   csum;
  logic signed [CORR_W-1:0] corr_sat;
  logic [UNIT_W-1:0]        unit_c;
  logic signed [CORR_W:0]   unit_s;

  always_comb begin
    if (mac_acc > PID_HI) begin
      u_c = PID_W'(PID_LIMIT);
    end else if (mac_acc < PID_LO) begin
      u_c = -PID_W'(PID_LIMIT);
    end else begin
      u_c = mac_acc[PID_W-1:0];
    end
    csum = {{(CORR_W+1-PID_W){u_c[PID_W-1]}}, u_c}
         + {correction_acc[CORR_W-1], correction_acc};
    if (csum[CORR_W] != csum[CORR_W-1]) begin
      corr_sat = {csum[CORR_W], {(CORR_W-1){~csum[CORR_W]}}};
    end else begin
      corr_sat = csum[CORR_W-1:0];
    end
    unit_c = (correction_unit < UNIT_W'(UNIT_MIN)) ? UNIT_W'(UNIT_MIN) : correction_unit;
    unit_s = {{(CORR_W+1-UNIT_W){1'b0}}, unit_c};
  end

  // ---- correction step during emit ----
  logic                     step_left;
  logic signed [CORR_W:0]   acc_ext, acc_stepped;
  logic signed [CORR_W-1:0] acc_new;
  logic [CNT_W-1:0]         cnt_new;
  logic                     more_new, more_first;

  always_comb begin
    acc_ext     = {correction_acc[CORR_W-1], correction_acc};
    step_left   = acc_ext > unit_s;
    acc_stepped = step_left ? (acc_ext - unit_s) : (acc_ext + unit_s);
    acc_new     = acc_stepped[CORR_W-1:0];   // moves toward zero, never overflows
    cnt_new     = res_cnt + 1'b1;
    more_new    = corr_more(acc_new, cnt_new, unit_s);
    more_first  = corr_more(correction_acc, CNT_W'(1), unit_s);
  end

  // ---- multiplier operand select and control ----
  always_comb begin
    mac_ctl = '0;
    mac_a   = gain_prop;
    mac_b   = error_sum;
    unique case (state)
      S_MUL_P: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.acc_clr = 1'b1;
        mac_a           = gain_prop;
        mac_b           = {{(SUM_W-ERR_W){previous_error[ERR_W-1]}}, previous_error};
      end
      S_MUL_I: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = 1'b1;
        mac_a          = gain_integ;
        mac_b          = error_sum;
      end
      S_MUL_D: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = 1'b1;
        mac_a          = gain_deriv;
        mac_b          = {{(SUM_W-DERIV_W){deriv_r[DERIV_W-1]}}, deriv_r};
      end
      S_ACC: begin
        mac_ctl.acc_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop       <= GAIN_W'(1);
      gain_integ      <= '0;
      gain_deriv      <= '0;
      front_on_level  <= LEVEL_W'(220);
      front_off_level <= LEVEL_W'(190);
      emergency_level <= LEVEL_W'(450);
      correction_unit <= UNIT_W'(70);
      steps_per_block <= SPB_W'(300);
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_PROP:       gain_prop       <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_INTEG:      gain_integ      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_DERIV:      gain_deriv      <= cfg_wdata[GAIN_W-1:0];
        REG_FRONT_ON_LEVEL:  front_on_level  <= cfg_wdata[LEVEL_W-1:0];
        REG_FRONT_OFF_LEVEL: front_off_level <= cfg_wdata[LEVEL_W-1:0];
        REG_EMERGENCY_LEVEL: emergency_level <= cfg_wdata[LEVEL_W-1:0];
        REG_CORRECTION_UNIT: correction_unit <= cfg_wdata[UNIT_W-1:0];
        REG_STEPS_PER_BLOCK: steps_per_block <= cfg_wdata[SPB_W-1:0];
      endcase
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      front_wall_flag  <= 1'b0;
      front_mask_count <= '0;
      lookahead_count  <= '0;
      error_sum        <= '0;
      previous_error   <= '0;
      correction_acc   <= '0;
      step_index       <= '0;
      block_active     <= 1'b0;
      res_cnt          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_r    <= op_t'(cmd.op);
            left_r  <= cmd.left_level;
            right_r <= cmd.right_level;
            front_r <= cmd.front_level;
            state   <= S_DECODE;
          end
        end

        S_DECODE: begin
          // status result unless a sample goes on to the PID
          out_left  <= 1'b0;
          out_right <= 1'b0;
          out_slow  <= 1'b0;
          out_last  <= 1'b1;
          res_cnt   <= CNT_W'(1);
          unique case (op_r)
            OP_START: begin
              block_active   <= 1'b1;
              step_index     <= '0;
              correction_acc <= '0;
              out_done       <= 1'b0;
              out_emer       <= 1'b0;
              state          <= S_EMIT;
            end
            OP_TURN: begin
              front_mask_count <= MASK_W'(MASK_STEPS);
              out_done         <= ~block_active;
              out_emer         <= 1'b0;
              state            <= S_EMIT;
            end
            OP_SAMPLE: begin
              if (block_active) begin
                if (front_mask_count != '0) begin
                  front_mask_count <= front_mask_count - 1'b1;
                end else begin
                  front_wall_flag <= flag_next;
                end
                if (front_r >= emergency_level) begin
                  block_active <= 1'b0;
                  out_done     <= 1'b1;
                  out_emer     <= 1'b1;
                  state        <= S_EMIT;
                end else begin
                  lookahead_count <= la_next;
                  slow_r          <= slow_c;
                  error_sum       <= es_next;
                  previous_error  <= err_c;
                  deriv_r         <= deriv_c;
                  step_index      <= step_next;
                  done_flag       <= end_c;
                  if (end_c) begin
                    block_active <= 1'b0;
                  end
                  state <= S_MUL_P;
                end
              end else begin
                // no block open: status only
                out_done <= 1'b1;
                out_emer <= 1'b0;
                state    <= S_EMIT;
              end
            end
            default: begin
              // unknown op: status only
              out_done <= ~block_active;
              out_emer <= 1'b0;
              state    <= S_EMIT;
            end
          endcase
        end

        S_MUL_P: state <= S_MUL_I;
        S_MUL_I: state <= S_MUL_D;
        S_MUL_D: state <= S_ACC;
        S_ACC:   state <= S_CLAMP;

        S_CLAMP: begin
          correction_acc <= corr_sat;
          state          <= S_LOAD;
        end

        S_LOAD: begin
          // both-wheel step first
          out_left  <= 1'b1;
          out_right <= 1'b1;
          out_slow  <= slow_r;
          out_emer  <= 1'b0;
          out_last  <= ~more_first;
          out_done  <= ~more_first & done_flag;
          res_cnt   <= CNT_W'(1);
          state     <= S_EMIT;
        end

        S_EMIT: begin
          if (res.ready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              correction_acc <= acc_new;
              out_left       <= step_left;
              out_right      <= ~step_left;
              out_last       <= ~more_new;
              out_done       <= ~more_new & done_flag;
              res_cnt        <= cnt_new;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready          = (state == S_IDLE);
  assign res.valid          = (state == S_EMIT);
  assign res.left_step      = out_left;
  assign res.right_step     = out_right;
  assign res.slow_mode      = out_slow;
  assign res.block_done     = out_done;
  assign res.emergency_stop = out_emer;
  assign res.last           = out_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && res.valid))
    else $error("command accepted while a result is pending");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res_cnt != '0) && (res_cnt <= CNT_W'(MAX_RESULTS)))
    else $error("result count out of range");

  a_emergency_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.emergency_stop |->
      res.last && res.block_done && !res.left_step && !res.right_step)
    else $error("malformed emergency result");

  a_inner_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.last |-> !res.block_done && (res.left_step || res.right_step))
    else $error("non-final result without a step or with done");

  a_return_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.last |=> cmd.ready)
    else $error("sequencer did not return to idle after final transfer");
`endif

endmodule
`default_nettype wire

// ===== dv/wall_centering_step_controller_test.sv =====
// ----------------------------------------------------------------------------
// wall_centering_step_controller_test: self-checking bench for the step controller
// Sends start, turn and sensor-sample items over the command channel. An
// in-bench copy of the controller (front wall hysteresis, post-turn mask,
// lookahead, clamped PID, correction accumulator, block length) builds the
// step pulses each item should cause, and every result transfer is compared
// field by field. Directed items hit the edges first, then random traffic runs
// under several register settings while both channels idle and stall.
// ----------------------------------------------------------------------------
module wall_centering_step_controller_test;
  import wcsc_pkg::*;

  // Op code 3 is not decoded by the block; it must come back as a status.
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // Bound on the whole run. The slowest correct run is roughly 470 items, each
  // with up to 40 results behind a choked receiver, plus sender gaps and the
  // one long hold-off.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Cycles to wait after the last result before touching the registers.
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_OFF_LEN = 400;

  // One result transfer as seen on the result channel.
  typedef struct packed {
    logic left_step;
    logic right_step;
    logic slow_mode;
    logic block_done;
    logic emergency_stop;
    logic last;
  } step_t;

  typedef enum int {RX_FREE, RX_COIN, RX_PATTERN, RX_CHOKE} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wcsc_cmd_if cmd_ch ();
  wcsc_res_if res_ch ();

  wall_centering_step_controller uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  // --------------------------------------------------------------------------
  // Bench-side copy of the controller registers and state
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [LEVEL_W-1:0]       wall_set_level, wall_clear_level, emer_level;
  logic [UNIT_W-1:0]        unit_reg;
  logic [SPB_W-1:0]         block_len;

  logic               wall_seen;
  logic [MASK_W-1:0]  mask_left;     // samples left with the front sensor masked
  logic [LOOK_W-1:0]  look_left;     // lookahead countdown
  int                 err_integral;  // saturating 32-bit sum of errors
  int                 err_prev;
  int                 corr_carry;    // 12-bit signed correction accumulator
  logic [SPB_W-1:0]   step_count;
  logic               in_block;

  step_t expected_steps[$];   // results still owed by the block, oldest first
  int    fail_count;
  int    cycle_count;

  // Stimulus pacing
  int       burst_left;       // transfers left in the current sender burst
  bit       sender_idle;      // sender may insert gaps between bursts
  int       hold_off_cycles;  // receiver holds ready low for this many cycles
  rx_mode_t rx_mode;

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: register writes and the per-item step sequence
  // --------------------------------------------------------------------------
  function automatic void reset_controller_copy();
    kp = 9'sd1;  ki = 9'sd0;  kd = 9'sd0;
    wall_set_level = 10'd220;  wall_clear_level = 10'd190;  emer_level = 10'd450;
    unit_reg = 10'd70;  block_len = 12'd300;
    wall_seen = 1'b0;  mask_left = '0;  look_left = '0;
    err_integral = 0;  err_prev = 0;  corr_carry = 0;
    step_count = '0;  in_block = 1'b0;
  endfunction

  function automatic void apply_reg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_PROP:       kp = data[GAIN_W-1:0];
      REG_GAIN_INTEG:      ki = data[GAIN_W-1:0];
      REG_GAIN_DERIV:      kd = data[GAIN_W-1:0];
      REG_FRONT_ON_LEVEL:  wall_set_level = data[LEVEL_W-1:0];
      REG_FRONT_OFF_LEVEL: wall_clear_level = data[LEVEL_W-1:0];
      REG_EMERGENCY_LEVEL: emer_level = data[LEVEL_W-1:0];
      REG_CORRECTION_UNIT: unit_reg = data[UNIT_W-1:0];
      REG_STEPS_PER_BLOCK: block_len = data[SPB_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the step pulses one accepted item causes and queues them.
  function automatic void compute_steps(logic [OP_W-1:0] op, logic [SENSOR_BITS-1:0] l,
                                        logic [SENSOR_BITS-1:0] r,
                                        logic [SENSOR_BITS-1:0] f);
    step_t  batch[$];
    logic   front_bit, slow, done;
    int     err, deriv, u, acc, unit, len;
    longint sum, mac;

    if (op == OP_START) begin
      in_block = 1'b1;
      step_count = '0;
      corr_carry = 0;
    end else if (op == OP_TURN) begin
      mask_left = MASK_STEPS[MASK_W-1:0];
    end
    // Start, turn, reserved op, or a sample outside a block: one status result.
    if (op != OP_SAMPLE || !in_block) begin
      expected_steps.push_back('{1'b0, 1'b0, 1'b0, !in_block, 1'b0, 1'b1});
      return;
    end

    // Front sensor: masked right after a turn, otherwise hysteresis.
    if (mask_left != 0) begin
      front_bit = 1'b0;
      mask_left--;
    end else begin
      if (f >= wall_set_level) wall_seen = 1'b1;
      else if (f <= wall_clear_level) wall_seen = 1'b0;
      front_bit = wall_seen;
    end

    // Emergency ends the block with a single stop result, even while masked.
    if (f >= emer_level) begin
      in_block = 1'b0;
      expected_steps.push_back('{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1});
      return;
    end

    if (front_bit && look_left == 0) look_left = LOOKAHEAD_STEPS[LOOK_W-1:0];
    if (look_left != 0) begin
      slow = 1'b0;
      look_left--;
    end else begin
      slow = front_bit;
    end

    // PID on left minus right, integral saturating at 32 bits.
    err = int'(l) - int'(r);
    sum = longint'(err_integral) + err;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    err_integral = int'(sum);
    deriv = err - err_prev;
    err_prev = err;
    mac = longint'(kp) * err + longint'(ki) * err_integral + longint'(kd) * deriv;
    if (mac > PID_LIMIT) mac = PID_LIMIT;
    if (mac < -PID_LIMIT) mac = -PID_LIMIT;
    u = int'(mac);

    acc = corr_carry + u;
    if (acc > 2047) acc = 2047;
    if (acc < -2048) acc = -2048;
    unit = (unit_reg < UNIT_MIN) ? UNIT_MIN : int'(unit_reg);
    len = (block_len == 0) ? 1 : int'(block_len);

    // Both wheels first, then single-wheel corrections, capped per sample.
    batch.push_back('{1'b1, 1'b1, slow, 1'b0, 1'b0, 1'b0});
    while (acc > unit && batch.size() <= MAX_CORR) begin
      batch.push_back('{1'b1, 1'b0, slow, 1'b0, 1'b0, 1'b0});
      acc -= unit;
    end
    while (acc < -unit && batch.size() <= MAX_CORR) begin
      batch.push_back('{1'b0, 1'b1, slow, 1'b0, 1'b0, 1'b0});
      acc += unit;
    end
    corr_carry = acc;

    step_count = step_count + 1'b1;
    done = (int'(step_count) >= len) || (step_count == 0);
    if (done) in_block = 1'b0;
    batch[batch.size()-1].block_done = done;
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_steps.push_back(batch[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every transfer against the oldest expected step
  // --------------------------------------------------------------------------
  function automatic void check_field(string field, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    step_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_steps.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = expected_steps.pop_front();
        check_field("left_step", want.left_step, res_ch.left_step);
        check_field("right_step", want.right_step, res_ch.right_step);
        check_field("slow_mode", want.slow_mode, res_ch.slow_mode);
        check_field("block_done", want.block_done, res_ch.block_done);
        check_field("emergency_stop", want.emergency_stop, res_ch.emergency_stop);
        check_field("last", want.last, res_ch.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: picks its own stall pattern anew each time the last one's random run ends.
  // A requested hold-off overrides it and is counted down here.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int mode_left;
    int rx_phase;
    mode_left = 0;
    rx_phase = 0;
    rx_mode = RX_FREE;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE:    res_ch.ready <= 1'b1;
          RX_COIN:    res_ch.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: res_ch.ready <= (rx_phase % 5 != 2) && (rx_phase % 3 != 0);
          default:    res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command driver and register port
  // --------------------------------------------------------------------------
  // Sends one item and returns at the edge of its transfer, valid still high;
  // the next call or settle() decides what valid does at the next falling edge.
  task automatic send_item(logic [OP_W-1:0] op, logic [SENSOR_BITS-1:0] l,
                           logic [SENSOR_BITS-1:0] r, logic [SENSOR_BITS-1:0] f);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_idle && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.op          <= op;
    cmd_ch.left_level  <= l;
    cmd_ch.right_level <= r;
    cmd_ch.front_level <= f;
    do @(posedge clk); while (!cmd_ch.ready);
    compute_steps(op, l, r, f);
  endtask

  // Drop valid, wait for every owed result, then let the block go idle.
  task automatic settle();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(cfg_reg_t idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wen <= 1'b0;
    apply_reg_write(idx, data);
  endtask

  // --------------------------------------------------------------------------
  // Random value helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gain();
    case ($urandom_range(0, 5))
      0:       return -256;
      1:       return 255;
      2:       return int'($urandom_range(0, 511)) - 256;
      default: return int'($urandom_range(0, 8)) - 4;   // mild gains dominate
    endcase
  endfunction

  function automatic int clamp_level(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // Front readings cluster around the thresholds and below the stop level so
  // that blocks run long enough to reach their end.
  function automatic logic [SENSOR_BITS-1:0] pick_front();
    case ($urandom_range(0, 9))
      0, 1: return SENSOR_BITS'($urandom_range(0, 1023));
      2:    return emer_level;
      3:    return SENSOR_BITS'(clamp_level(int'(emer_level) - 1));
      4:    return SENSOR_BITS'(clamp_level(int'(wall_set_level) +
                                            int'($urandom_range(0, 4)) - 2));
      5:    return SENSOR_BITS'(clamp_level(int'(wall_clear_level) +
                                            int'($urandom_range(0, 4)) - 2));
      default:
        if (emer_level == 0) return SENSOR_BITS'($urandom_range(0, 1023));
        else return SENSOR_BITS'($urandom_range(0, int'(emer_level) - 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Status items: sample with no block, turn, reserved op, start, restart.
  task automatic test_status_items();
    send_item(OP_SAMPLE, 10'd0, 10'd0, 10'd0);
    send_item(OP_TURN, 10'd1023, 10'd1023, 10'd1023);
    send_item(OP_RESERVED, 10'd1023, 10'd1023, 10'd1023);
    send_item(OP_START, 10'd0, 10'd0, 10'd0);
    send_item(OP_START, 10'd512, 10'd511, 10'd700);   // restart while active
  endtask

  // Largest errors both ways drive the PID into its clamp; front still masked.
  task automatic test_centering_extremes();
    send_item(OP_SAMPLE, 10'd1023, 10'd0, 10'd100);
    send_item(OP_SAMPLE, 10'd0, 10'd1023, 10'd100);
    send_item(OP_SAMPLE, 10'd512, 10'd512, 10'd0);
    send_item(OP_SAMPLE, 10'd1023, 10'd1023, 10'd449);
    send_item(OP_SAMPLE, 10'd0, 10'd0, 10'd1023);     // stop while masked
  endtask

  // Emergency at exactly the level, hysteresis edges, turn inside a block.
  task automatic test_front_sensor();
    send_item(OP_START, 10'd0, 10'd0, 10'd0);
    send_item(OP_SAMPLE, 10'd300, 10'd200, 10'd450);
    send_item(OP_START, 10'd0, 10'd0, 10'd0);
    send_item(OP_SAMPLE, 10'd200, 10'd300, 10'd449);
    send_item(OP_SAMPLE, 10'd100, 10'd90, 10'd220);
    send_item(OP_SAMPLE, 10'd90, 10'd100, 10'd190);
    send_item(OP_TURN, 10'd0, 10'd0, 10'd0);
    send_item(OP_SAMPLE, 10'd5, 10'd5, 10'd1023);
  endtask

  // Every register at an extreme: unit below the floor, zero block length,
  // then the longest block with a zero stop level.
  task automatic test_register_extremes();
    settle();
    write_reg(REG_GAIN_PROP, -256);
    write_reg(REG_GAIN_INTEG, 255);
    write_reg(REG_GAIN_DERIV, -256);
    write_reg(REG_FRONT_ON_LEVEL, 0);
    write_reg(REG_FRONT_OFF_LEVEL, 1023);
    write_reg(REG_EMERGENCY_LEVEL, 1023);
    write_reg(REG_CORRECTION_UNIT, 0);
    write_reg(REG_STEPS_PER_BLOCK, 0);
    send_item(OP_START, 10'd0, 10'd0, 10'd0);
    send_item(OP_SAMPLE, 10'd1023, 10'd0, 10'd1022);  // ends the block at once
    send_item(OP_START, 10'd0, 10'd0, 10'd0);
    send_item(OP_SAMPLE, 10'd0, 10'd1023, 10'd0);
    settle();
    write_reg(REG_GAIN_PROP, 255);
    write_reg(REG_GAIN_DERIV, 255);
    write_reg(REG_EMERGENCY_LEVEL, 0);
    write_reg(REG_CORRECTION_UNIT, 1023);
    write_reg(REG_STEPS_PER_BLOCK, 4095);
    send_item(OP_START, 10'd0, 10'd0, 10'd0);
    send_item(OP_SAMPLE, 10'd5, 10'd3, 10'd0);        // any reading stops
  endtask

  // Long receiver hold-off while samples with long correction runs keep
  // coming: the result channel stalls and the command channel backs up.
  task automatic test_output_backpressure();
    settle();
    write_reg(REG_GAIN_PROP, 255);
    write_reg(REG_GAIN_INTEG, 0);
    write_reg(REG_GAIN_DERIV, 0);
    write_reg(REG_EMERGENCY_LEVEL, 1023);
    write_reg(REG_CORRECTION_UNIT, 8);
    hold_off_cycles = HOLD_OFF_LEN;
    send_item(OP_START, 10'd0, 10'd0, 10'd0);
    for (int i = 0; i < 10; i++) begin
      if (i % 3 == 2) send_item(OP_SAMPLE, 10'd0, 10'd1023, 10'd10);
      else send_item(OP_SAMPLE, 10'd1023, 10'd0, 10'd10);
    end
  endtask

  task automatic apply_random_settings();
    write_reg(REG_GAIN_PROP, pick_gain());
    write_reg(REG_GAIN_INTEG, pick_gain());
    write_reg(REG_GAIN_DERIV, pick_gain());
    write_reg(REG_FRONT_ON_LEVEL, $urandom_range(0, 1023));
    write_reg(REG_FRONT_OFF_LEVEL, $urandom_range(0, 1023));
    if ($urandom_range(0, 9) < 7) write_reg(REG_EMERGENCY_LEVEL, $urandom_range(600, 1023));
    else write_reg(REG_EMERGENCY_LEVEL, $urandom_range(0, 1023));
    case ($urandom_range(0, 4))
      0:       write_reg(REG_CORRECTION_UNIT, $urandom_range(0, 8));
      1:       write_reg(REG_CORRECTION_UNIT, $urandom_range(8, 1023));
      default: write_reg(REG_CORRECTION_UNIT, $urandom_range(8, 200));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(REG_STEPS_PER_BLOCK, 0);
      1:       write_reg(REG_STEPS_PER_BLOCK, 4095);
      default: write_reg(REG_STEPS_PER_BLOCK, $urandom_range(1, 24));
    endcase
  endtask

  // Mostly well-formed blocks: start, a run of samples with an occasional
  // turn or restart; stray samples and reserved ops as noise between blocks.
  task automatic run_random_blocks(int item_count);
    int                     sent, pick, t;
    bit                     ignored;
    logic [OP_W-1:0]        op;
    logic [SENSOR_BITS-1:0] l, r, f;
    sent = 0;
    while (sent < item_count) begin
      pick = $urandom_range(0, 99);
      if (!in_block)
        op = (pick < 75) ? OP_START : (pick < 85) ? OP_SAMPLE :
             (pick < 93) ? OP_TURN : OP_RESERVED;
      else
        op = (pick < 86) ? OP_SAMPLE : (pick < 92) ? OP_TURN :
             (pick < 96) ? OP_START : OP_RESERVED;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          l = SENSOR_BITS'($urandom_range(0, 1023));
          r = SENSOR_BITS'($urandom_range(0, 1023));
        end
        8: begin
          l = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          r = ~l;
        end
        9: begin
          l = SENSOR_BITS'($urandom_range(0, 1023));
          r = l;
        end
        default: begin
          l = SENSOR_BITS'($urandom_range(0, 1023));
          t = clamp_level(int'(l) + int'($urandom_range(0, 80)) - 40);
          r = SENSOR_BITS'(t);
        end
      endcase
      f = pick_front();
      ignored = (op == OP_RESERVED) || (op == OP_SAMPLE && !in_block);
      send_item(op, l, r, f);
      if (!ignored) sent++;
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      sender_idle = (phase % 3 != 1);   // one phase in three runs back to back
      apply_random_settings();
      run_random_blocks(70);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = REG_GAIN_PROP;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.op = OP_SAMPLE;
    cmd_ch.left_level = '0;
    cmd_ch.right_level = '0;
    cmd_ch.front_level = '0;
    fail_count = 0;
    burst_left = 0;
    sender_idle = 1'b1;
    hold_off_cycles = 0;
    reset_controller_copy();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_status_items();
    test_centering_extremes();
    test_front_sensor();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    settle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wcsc_pkg.sv
hw/rtl/wcsc_if.sv
hw/rtl/wcsc_mac.sv
hw/rtl/wall_centering_step_controller.sv
dv/wall_centering_step_controller_test.sv
